FILE: rtl/pfb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfb_pkg
// Shared types and constants of the page frame store with bitmap blitter.
// ----------------------------------------------------------------------------
package pfb_pkg;

  localparam int SCREEN_WIDTH_DEF  = 84;
  localparam int SCREEN_HEIGHT_DEF = 48;
  localparam int PADDR_W           = 5;
  localparam logic [3:0] THRESH_MAX = 4'd14;

  typedef enum logic [2:0] {
    CMD_SET_PIXEL  = 3'd0,
    CMD_CLR_PIXEL  = 3'd1,
    CMD_START_BLIT = 3'd2,
    CMD_BLIT_BYTE  = 3'd3,
    CMD_READ_BYTE  = 3'd4,
    CMD_WRITE_BYTE = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_RANGE   = 2'd1,
    STS_REJECT  = 2'd2,
    STS_NO_BLIT = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SQ_CLEAR,
    SQ_IDLE,
    SQ_WB
  } seq_state_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [6:0] pos_x;
    logic [5:0] pos_y;
    logic [7:0] value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    status_t    status;
    logic       blit_done;
  } out_item_t;

  typedef struct packed {
    logic [6:0] origin_x;
    logic [5:0] origin_y;
    logic [6:0] image_width;
    logic [5:0] image_height;
    logic [3:0] gray_threshold;
  } cfg_t;

endpackage
`default_nettype wire

FILE: rtl/pfb_bank.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfb_bank
// Single-port frame store bank with registered read data.
// ----------------------------------------------------------------------------
module pfb_bank #(
  parameter int DEPTH = 252,
  parameter int AW    = 8
) (
  input  wire logic          clk,
  input  wire logic          rd_en,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] addr,
  input  wire logic [7:0]    wdata,
  output logic      [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

FILE: rtl/pfb_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfb_regs
// APB configuration registers: image origin, size and gray threshold.
// ----------------------------------------------------------------------------
module pfb_regs (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [pfb_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready,
  output pfb_pkg::cfg_t                   cfg
);
  import pfb_pkg::*;

  typedef enum logic [2:0] {
    REG_ORIGIN_X       = 3'd0,
    REG_ORIGIN_Y       = 3'd1,
    REG_IMAGE_WIDTH    = 3'd2,
    REG_IMAGE_HEIGHT   = 3'd3,
    REG_GRAY_THRESHOLD = 3'd4
  } reg_idx_t;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x       <= 7'd0;
      cfg_r.origin_y       <= 6'd47;
      cfg_r.image_width    <= 7'd2;
      cfg_r.image_height   <= 6'd1;
      cfg_r.gray_threshold <= 4'd0;
    end else if (wr_en) begin
      case (idx)
        REG_ORIGIN_X:       cfg_r.origin_x       <= pwdata[6:0];
        REG_ORIGIN_Y:       cfg_r.origin_y       <= pwdata[5:0];
        REG_IMAGE_WIDTH:    cfg_r.image_width    <= pwdata[6:0];
        REG_IMAGE_HEIGHT:   cfg_r.image_height   <= pwdata[5:0];
        REG_GRAY_THRESHOLD: cfg_r.gray_threshold <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ORIGIN_X:       prdata = {25'd0, cfg_r.origin_x};
      REG_ORIGIN_Y:       prdata = {26'd0, cfg_r.origin_y};
      REG_IMAGE_WIDTH:    prdata = {25'd0, cfg_r.image_width};
      REG_IMAGE_HEIGHT:   prdata = {26'd0, cfg_r.image_height};
      REG_GRAY_THRESHOLD: prdata = {28'd0, cfg_r.gray_threshold};
      default:            prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/page_framebuffer_bmp_blit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// page_framebuffer_bmp_blit
// Page-organized monochrome frame store with a 4bpp bitmap blitter.
// ----------------------------------------------------------------------------
// Commands enter on start/in_item and are taken when busy is low. Each
// command gives one result on out_item, marked by out_valid for one cycle;
// the receiver cannot stall, so results are never held back.
// Commands that need no read-modify-write (start blit, write byte, padding
// bytes, unused codes, errors) return their result in the cycle after
// acceptance and the next command can follow in the next cycle. Pixel
// set/clear, read byte and blit data bytes use a write-back state: the store
// is split into an even-column and an odd-column bank, the bank or banks
// holding the addressed columns are read in the accept cycle and, but for
// read byte, written back in the following cycle while busy holds off the
// next command; the result is registered at the end of that state. After
// reset both banks are cleared one entry per cycle, busy held high meanwhile.
// The APB port may be written at any time the block holds no command.
// ----------------------------------------------------------------------------
module page_framebuffer_bmp_blit #(
  parameter int SCREEN_WIDTH  = pfb_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = pfb_pkg::SCREEN_HEIGHT_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire pfb_pkg::in_item_t           in_item,
  output logic                             out_valid,
  output pfb_pkg::out_item_t               out_item,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [pfb_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready
);
  import pfb_pkg::*;

  localparam int FB_PAGES   = (SCREEN_HEIGHT + 7) / 8;
  localparam int HALF_W     = (SCREEN_WIDTH + 1) / 2;
  localparam int BANK_DEPTH = FB_PAGES * HALF_W;
  localparam int AW         = $clog2(BANK_DEPTH);
  localparam int COL_W      = 9;

  cfg_t cfg;

  seq_state_t state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;

  logic       blit_active_r, blit_active_nxt;
  logic [5:0] pair_r, pair_nxt;
  logic [2:0] page_r, page_nxt;
  logic [2:0] bit_r, bit_nxt;
  logic [5:0] rows_r, rows_nxt;
  logic [1:0] pad_r, pad_nxt;

  logic [1:0]    wb_en_r, wb_en_nxt;
  logic [1:0]    wb_on_r, wb_on_nxt;
  logic [AW-1:0] wb_addr_r [2];
  logic [AW-1:0] wb_addr_nxt [2];
  logic [2:0]    wb_bit_r, wb_bit_nxt;
  logic          rd_op_r, rd_op_nxt;
  logic          rd_bank_r, rd_bank_nxt;
  logic          wb_done_r, wb_done_nxt;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_nxt;

  logic [1:0]    bk_re;
  logic [1:0]    bk_we;
  logic [AW-1:0] bk_addr [2];
  logic [7:0]    bk_wdata [2];
  logic [7:0]    bk_rdata [2];

  logic accept;
  logic go_wb;

  function automatic logic [AW-1:0] bank_addr(input logic [2:0] page,
                                               input logic [7:0] half_col);
    bank_addr = AW'(int'(page) * HALF_W + int'(half_col));
  endfunction

  pfb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  for (genvar b = 0; b < 2; b++) begin : g_bank
    pfb_bank #(
      .DEPTH (BANK_DEPTH),
      .AW    (AW)
    ) u_bank (
      .clk   (clk),
      .rd_en (bk_re[b]),
      .wr_en (bk_we[b]),
      .addr  (bk_addr[b]),
      .wdata (bk_wdata[b]),
      .rdata (bk_rdata[b])
    );
  end

  assign busy      = (state_r != SQ_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SQ_CLEAR: begin
        if (clr_cnt_r == AW'(BANK_DEPTH - 1)) begin
          state_nxt = SQ_IDLE;
        end
      end
      SQ_IDLE: begin
        if (accept && go_wb) begin
          state_nxt = SQ_WB;
        end
      end
      SQ_WB:   state_nxt = SQ_IDLE;
      default: state_nxt = SQ_CLEAR;
    endcase
  end

  // Command decode, memory access and blit walker
  always_comb begin
    logic [3:0]       th;
    logic [COL_W-1:0] c0;
    logic [COL_W-1:0] c1;
    logic [COL_W-1:0] x_end;
    logic             page_ok;
    logic             b0;
    logic [5:0]       pair_inc;
    logic [5:0]       half;
    logic [5:0]       rows_dec;
    logic [7:0]       mask;
    out_item_t        res;

    th       = (cfg.gray_threshold > THRESH_MAX) ? THRESH_MAX : cfg.gray_threshold;
    c0       = COL_W'(cfg.origin_x) + COL_W'({pair_r, 1'b0});
    c1       = c0 + COL_W'(1);
    x_end    = COL_W'(cfg.origin_x) + COL_W'(cfg.image_width);
    page_ok  = ({4'd0, page_r} < 7'(FB_PAGES));
    b0       = c0[0];
    pair_inc = pair_r + 6'd1;
    half     = cfg.image_width[6:1];
    rows_dec = rows_r - 6'd1;
    mask     = 8'(8'h01 << wb_bit_r);
    res      = '0;

    clr_cnt_nxt     = clr_cnt_r;
    blit_active_nxt = blit_active_r;
    pair_nxt        = pair_r;
    page_nxt        = page_r;
    bit_nxt         = bit_r;
    rows_nxt        = rows_r;
    pad_nxt         = pad_r;
    wb_en_nxt       = wb_en_r;
    wb_on_nxt       = wb_on_r;
    wb_addr_nxt     = wb_addr_r;
    wb_bit_nxt      = wb_bit_r;
    rd_op_nxt       = rd_op_r;
    rd_bank_nxt     = rd_bank_r;
    wb_done_nxt     = wb_done_r;
    out_valid_nxt   = 1'b0;
    out_item_nxt    = out_item_r;
    go_wb           = 1'b0;
    bk_re           = 2'b00;
    bk_we           = 2'b00;
    bk_addr[0]      = '0;
    bk_addr[1]      = '0;
    bk_wdata[0]     = 8'd0;
    bk_wdata[1]     = 8'd0;

    case (state_r)
      SQ_CLEAR: begin
        bk_we       = 2'b11;
        bk_addr[0]  = clr_cnt_r;
        bk_addr[1]  = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
      end

      SQ_IDLE: begin
        if (accept) begin
          wb_en_nxt   = 2'b00;
          rd_op_nxt   = 1'b0;
          wb_done_nxt = 1'b0;
          case (in_item.cmd)
            CMD_SET_PIXEL, CMD_CLR_PIXEL: begin
              if ({2'b00, in_item.pos_x} >= COL_W'(SCREEN_WIDTH) ||
                  {1'b0, in_item.pos_y} >= 7'(SCREEN_HEIGHT)) begin
                res.status = STS_RANGE;
              end else begin
                bk_re[in_item.pos_x[0]]       = 1'b1;
                bk_addr[in_item.pos_x[0]]     = bank_addr(in_item.pos_y[5:3],
                                                          {2'b00, in_item.pos_x[6:1]});
                wb_en_nxt[in_item.pos_x[0]]   = 1'b1;
                wb_addr_nxt[in_item.pos_x[0]] = bk_addr[in_item.pos_x[0]];
                wb_on_nxt[in_item.pos_x[0]]   = (in_item.cmd == CMD_SET_PIXEL);
                wb_bit_nxt                    = in_item.pos_y[2:0];
                go_wb                         = 1'b1;
              end
            end

            CMD_START_BLIT: begin
              if (cfg.image_height == 6'd0 || cfg.image_width[0] ||
                  cfg.image_width == 7'd0 || x_end > COL_W'(SCREEN_WIDTH) ||
                  ({1'b0, cfg.origin_y} + 7'd1) < {1'b0, cfg.image_height} ||
                  {1'b0, cfg.origin_y} >= 7'(SCREEN_HEIGHT)) begin
                blit_active_nxt = 1'b0;
                res.status      = STS_REJECT;
              end else begin
                blit_active_nxt = 1'b1;
                pair_nxt        = 6'd0;
                page_nxt        = cfg.origin_y[5:3];
                bit_nxt         = cfg.origin_y[2:0];
                rows_nxt        = cfg.image_height;
                pad_nxt         = 2'd0;
              end
            end

            CMD_BLIT_BYTE: begin
              if (!blit_active_r) begin
                res.status = STS_NO_BLIT;
              end else if (pad_r != 2'd0) begin
                // consume a row padding byte
                pad_nxt = pad_r - 2'd1;
              end else begin
                // left pixel in the bank of c0, right pixel in the other one
                bk_re[b0]        = page_ok && (c0 < COL_W'(SCREEN_WIDTH));
                bk_re[~b0]       = page_ok && (c1 < COL_W'(SCREEN_WIDTH));
                bk_addr[b0]      = bank_addr(page_r, c0[COL_W-1:1]);
                bk_addr[~b0]     = bank_addr(page_r, c1[COL_W-1:1]);
                wb_en_nxt        = bk_re;
                wb_addr_nxt[0]   = bk_addr[0];
                wb_addr_nxt[1]   = bk_addr[1];
                wb_on_nxt[b0]    = (in_item.value[7:4] > th);
                wb_on_nxt[~b0]   = (in_item.value[3:0] > th);
                wb_bit_nxt       = bit_r;
                go_wb            = 1'b1;
                if (pair_inc >= half) begin
                  pair_nxt = 6'd0;
                  rows_nxt = rows_dec;
                  if (rows_dec == 6'd0) begin
                    blit_active_nxt = 1'b0;
                    wb_done_nxt     = 1'b1;
                  end else begin
                    // advance one screen row up
                    if (bit_r != 3'd0) begin
                      bit_nxt = bit_r - 3'd1;
                    end else begin
                      bit_nxt  = 3'd7;
                      page_nxt = page_r - 3'd1;
                    end
                    pad_nxt = 2'(6'd0 - half);
                  end
                end else begin
                  pair_nxt = pair_inc;
                end
              end
            end

            CMD_READ_BYTE: begin
              if ({2'b00, in_item.pos_x} >= COL_W'(SCREEN_WIDTH) ||
                  {1'b0, in_item.pos_y} >= 7'(FB_PAGES)) begin
                res.status = STS_RANGE;
              end else begin
                bk_re[in_item.pos_x[0]]   = 1'b1;
                bk_addr[in_item.pos_x[0]] = bank_addr(in_item.pos_y[2:0],
                                                      {2'b00, in_item.pos_x[6:1]});
                rd_op_nxt                 = 1'b1;
                rd_bank_nxt               = in_item.pos_x[0];
                go_wb                     = 1'b1;
              end
            end

            CMD_WRITE_BYTE: begin
              if ({2'b00, in_item.pos_x} >= COL_W'(SCREEN_WIDTH) ||
                  {1'b0, in_item.pos_y} >= 7'(FB_PAGES)) begin
                res.status = STS_RANGE;
              end else begin
                bk_we[in_item.pos_x[0]]    = 1'b1;
                bk_addr[in_item.pos_x[0]]  = bank_addr(in_item.pos_y[2:0],
                                                       {2'b00, in_item.pos_x[6:1]});
                bk_wdata[in_item.pos_x[0]] = in_item.value;
              end
            end

            default: ;
          endcase

          if (!go_wb) begin
            out_valid_nxt = 1'b1;
            out_item_nxt  = res;
          end
        end
      end

      SQ_WB: begin
        for (int b = 0; b < 2; b++) begin
          bk_we[b]    = wb_en_r[b];
          bk_addr[b]  = wb_addr_r[b];
          bk_wdata[b] = wb_on_r[b] ? (bk_rdata[b] | mask) : (bk_rdata[b] & ~mask);
        end
        out_valid_nxt          = 1'b1;
        out_item_nxt.read_data = rd_op_r ? bk_rdata[rd_bank_r] : 8'd0;
        out_item_nxt.status    = STS_OK;
        out_item_nxt.blit_done = wb_done_r;
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= SQ_CLEAR;
      clr_cnt_r     <= '0;
      blit_active_r <= 1'b0;
      pair_r        <= 6'd0;
      page_r        <= 3'd0;
      bit_r         <= 3'd0;
      rows_r        <= 6'd0;
      pad_r         <= 2'd0;
      wb_en_r       <= 2'b00;
      rd_op_r       <= 1'b0;
      wb_done_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      clr_cnt_r     <= clr_cnt_nxt;
      blit_active_r <= blit_active_nxt;
      pair_r        <= pair_nxt;
      page_r        <= page_nxt;
      bit_r         <= bit_nxt;
      rows_r        <= rows_nxt;
      pad_r         <= pad_nxt;
      wb_en_r       <= wb_en_nxt;
      rd_op_r       <= rd_op_nxt;
      wb_done_r     <= wb_done_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wb_on_r      <= wb_on_nxt;
    wb_addr_r    <= wb_addr_nxt;
    wb_bit_r     <= wb_bit_nxt;
    rd_bank_r    <= rd_bank_nxt;
    out_item_r   <= out_item_nxt;
  end

  // Every accepted transaction either answers next cycle or holds busy
  a_accept_answers: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (out_valid_r || state_r == SQ_WB))
    else $error("accepted transaction neither answered nor in write-back");

  a_wb_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == SQ_WB) |=> (out_valid_r && state_r == SQ_IDLE))
    else $error("write-back did not complete in one cycle");

  a_err_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.status != STS_OK) |->
      (out_item_r.read_data == 8'd0 && !out_item_r.blit_done))
    else $error("error result carries data");

  a_done_ends_blit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.blit_done) |-> !blit_active_r)
    else $error("blit still active after last row");

endmodule
`default_nettype wire

FILE: bench/tb_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the page frame store with 4bpp bitmap blitter.
// Commands go in over start/busy. Each accepted command is run through a
// local copy of the frame store and blitter state, and the expected result is
// queued. Each out_valid result is checked field by field against the head of
// that queue. Directed edge cases come first, then random traffic: mostly
// well-formed blits with random content under random register settings, mixed
// with pixel/byte traffic, rejected geometries, truncated and restarted blits,
// and register changes in the middle of a blit.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pfb_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int SCREEN_W    = SCREEN_WIDTH_DEF;
  localparam int SCREEN_H    = SCREEN_HEIGHT_DEF;
  localparam int N_PAGES     = (SCREEN_H + 7) / 8;
  localparam int FB_BYTES    = SCREEN_W * N_PAGES;
  localparam int TAIL_CYCLES = 4;
  localparam int TIMEOUT_NS  = 5_000_000;

  localparam logic [PADDR_W-1:0] ADDR_ORIGIN_X = PADDR_W'(0);
  localparam logic [PADDR_W-1:0] ADDR_ORIGIN_Y = PADDR_W'(4);
  localparam logic [PADDR_W-1:0] ADDR_WIDTH    = PADDR_W'(8);
  localparam logic [PADDR_W-1:0] ADDR_HEIGHT   = PADDR_W'(12);
  localparam logic [PADDR_W-1:0] ADDR_THRESH   = PADDR_W'(16);

  // command codes the block leaves unused
  localparam logic [2:0] CMD_NOP6 = 3'd6;
  localparam logic [2:0] CMD_NOP7 = 3'd7;

  logic               clk     = 1'b0;
  logic               rst_n   = 1'b0;
  logic               start   = 1'b0;
  in_item_t           in_item = '0;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [31:0]        pwdata  = '0;
  logic               busy;
  logic               out_valid;
  out_item_t          out_item;
  logic [31:0]        prdata;
  logic               pready;

  page_framebuffer_bmp_blit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Shadow of the frame store, blitter position and registers
  logic [7:0] fb_mem [FB_BYTES];
  logic       blit_on;
  logic [5:0] col_pair;
  logic [2:0] cur_page;
  logic [2:0] cur_bit;
  logic [5:0] rows_todo;
  logic [1:0] pad_todo;
  cfg_t       live_cfg;

  out_item_t  pending_results [$];
  out_item_t  want;
  int         fail_count = 0;
  int         sent_items = 0;
  int         idle_pct   = 0;
  int         reject_seq = 0;

  function automatic in_item_t mk_cmd(logic [2:0] op, logic [6:0] x, logic [5:0] y,
                                      logic [7:0] v);
    in_item_t r;
    r.cmd   = cmd_t'(op);
    r.pos_x = x;
    r.pos_y = y;
    r.value = v;
    return r;
  endfunction

  function automatic void plot(int col, int page, int row_bit, bit on);
    if (col >= SCREEN_W || page >= N_PAGES) return;
    fb_mem[page * SCREEN_W + col][row_bit] = on;
  endfunction

  // Apply one command to the shadow state and return its result
  function automatic out_item_t predict_frame_op(in_item_t it);
    out_item_t  r;
    logic [3:0] th;
    int         half;
    int         col;
    r = '0;
    r.status = STS_OK;
    case (it.cmd)
      CMD_SET_PIXEL, CMD_CLR_PIXEL: begin
        if (it.pos_x >= SCREEN_W || it.pos_y >= SCREEN_H) begin
          r.status = STS_RANGE;
        end else begin
          plot(it.pos_x, it.pos_y >> 3, it.pos_y[2:0], it.cmd == CMD_SET_PIXEL);
        end
      end
      CMD_START_BLIT: begin
        if (live_cfg.image_height == 0 || live_cfg.image_width[0] ||
            live_cfg.image_width == 0 ||
            int'(live_cfg.origin_x) + int'(live_cfg.image_width) > SCREEN_W ||
            int'(live_cfg.origin_y) < int'(live_cfg.image_height) - 1 ||
            live_cfg.origin_y >= SCREEN_H) begin
          blit_on  = 1'b0;
          r.status = STS_REJECT;
        end else begin
          blit_on   = 1'b1;
          col_pair  = '0;
          cur_page  = live_cfg.origin_y[5:3];
          cur_bit   = live_cfg.origin_y[2:0];
          rows_todo = live_cfg.image_height;
          pad_todo  = '0;
        end
      end
      CMD_BLIT_BYTE: begin
        if (!blit_on) begin
          r.status = STS_NO_BLIT;
        end else if (pad_todo != 0) begin
          pad_todo = pad_todo - 2'd1;
        end else begin
          th   = (live_cfg.gray_threshold > THRESH_MAX) ? THRESH_MAX : live_cfg.gray_threshold;
          half = int'(live_cfg.image_width >> 1);
          col  = int'(live_cfg.origin_x) + 2 * int'(col_pair);
          plot(col, cur_page, cur_bit, it.value[7:4] > th);
          plot(col + 1, cur_page, cur_bit, it.value[3:0] > th);
          col_pair = col_pair + 6'd1;
          if (int'(col_pair) >= half) begin
            col_pair  = '0;
            rows_todo = rows_todo - 6'd1;
            if (rows_todo == 0) begin
              blit_on     = 1'b0;
              r.blit_done = 1'b1;
            end else begin
              if (cur_bit > 0) begin
                cur_bit = cur_bit - 3'd1;
              end else begin
                cur_bit  = 3'd7;
                cur_page = cur_page - 3'd1;
              end
              // skip the bytes that pad each row to 32 bits
              pad_todo = 2'((4 - (half & 3)) & 3);
            end
          end
        end
      end
      CMD_READ_BYTE, CMD_WRITE_BYTE: begin
        if (it.pos_x >= SCREEN_W || it.pos_y >= N_PAGES) begin
          r.status = STS_RANGE;
        end else if (it.cmd == CMD_READ_BYTE) begin
          r.read_data = fb_mem[it.pos_y * SCREEN_W + it.pos_x];
        end else begin
          fb_mem[it.pos_y * SCREEN_W + it.pos_x] = it.value;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Check each result against the oldest pending expectation
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: read_data=%0d status=%0d blit_done=%0d",
               out_item.read_data, out_item.status, out_item.blit_done);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_item.read_data !== want.read_data) begin
          $error("read_data: expected %0d, got %0d", want.read_data, out_item.read_data);
          fail_count++;
        end
        if (out_item.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_item.status);
          fail_count++;
        end
        if (out_item.blit_done !== want.blit_done) begin
          $error("blit_done: expected %0d, got %0d", want.blit_done, out_item.blit_done);
          fail_count++;
        end
      end
    end
  end

  // Send one transaction; start stays high afterwards unless a gap follows
  task automatic send_cmd(in_item_t it);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(predict_frame_op(it));
    sent_items++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [PADDR_W-1:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (addr)
      ADDR_ORIGIN_X: live_cfg.origin_x       = data[6:0];
      ADDR_ORIGIN_Y: live_cfg.origin_y       = data[5:0];
      ADDR_WIDTH:    live_cfg.image_width    = data[6:0];
      ADDR_HEIGHT:   live_cfg.image_height   = data[5:0];
      ADDR_THRESH:   live_cfg.gray_threshold = data[3:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_geometry(int ox, int oy, int w, int h, int th);
    cfg_write(ADDR_ORIGIN_X, 32'(ox));
    cfg_write(ADDR_ORIGIN_Y, 32'(oy));
    cfg_write(ADDR_WIDTH, 32'(w));
    cfg_write(ADDR_HEIGHT, 32'(h));
    cfg_write(ADDR_THRESH, 32'(th));
  endtask

  // Pixel, byte and unused-code traffic that leaves an active blit alone
  task automatic send_side_op();
    int         pick;
    logic [6:0] x;
    logic [5:0] y;
    pick = $urandom_range(0, 9);
    x = ($urandom_range(99) < 85) ? 7'($urandom_range(0, SCREEN_W - 1))
                                  : 7'($urandom_range(0, 127));
    if (pick < 4) begin
      y = ($urandom_range(99) < 85) ? 6'($urandom_range(0, SCREEN_H - 1))
                                    : 6'($urandom_range(0, 63));
      send_cmd(mk_cmd(pick < 2 ? CMD_SET_PIXEL : CMD_CLR_PIXEL, x, y, 8'($urandom)));
    end else if (pick < 9) begin
      y = ($urandom_range(99) < 85) ? 6'($urandom_range(0, N_PAGES - 1))
                                    : 6'($urandom_range(0, 63));
      send_cmd(mk_cmd(pick < 6 ? CMD_READ_BYTE : CMD_WRITE_BYTE, x, y, 8'($urandom)));
    end else begin
      send_cmd(mk_cmd($urandom_range(1) ? CMD_NOP6 : CMD_NOP7, x, 6'($urandom), 8'($urandom)));
    end
  endtask

  // Any command at all, blit control included
  task automatic send_noise();
    logic [5:0] y;
    case ($urandom_range(0, 2))
      0:       y = 6'($urandom_range(0, N_PAGES - 1));
      1:       y = 6'($urandom_range(0, SCREEN_H - 1));
      default: y = 6'($urandom_range(0, 63));
    endcase
    send_cmd(mk_cmd(3'($urandom_range(0, 7)), 7'($urandom_range(0, 127)), y, 8'($urandom)));
  endtask

  // Valid geometry, or a rejected one cycling through every rejection rule
  task automatic pick_geometry(bit bad);
    int w, h, ox, oy;
    w  = 2 * $urandom_range(1, 8);
    h  = $urandom_range(1, 6);
    ox = $urandom_range(0, SCREEN_W - w);
    oy = $urandom_range(h - 1, SCREEN_H - 1);
    if (bad) begin
      case (reject_seq % 6)
        0: h = 0;
        1: w = 2 * $urandom_range(0, 63) + 1;
        2: w = 0;
        3: ox = $urandom_range(SCREEN_W - w + 1, 127);
        4: begin
          h  = $urandom_range(2, 63);
          oy = $urandom_range(0, h - 2);
        end
        default: oy = $urandom_range(SCREEN_H, 63);
      endcase
      reject_seq++;
    end else if ($urandom_range(99) < 8) begin
      case ($urandom_range(0, 2))
        0: begin
          w  = SCREEN_W;
          ox = 0;
          h  = $urandom_range(1, 6);
          oy = $urandom_range(h - 1, SCREEN_H - 1);
        end
        1: begin
          w  = 2;
          ox = $urandom_range(0, SCREEN_W - 2);
          h  = SCREEN_H;
          oy = SCREEN_H - 1;
        end
        default: begin
          w  = 2;
          ox = SCREEN_W - 2;
          h  = 1;
          oy = 0;
        end
      endcase
    end
    load_geometry(ox, oy, w, h, $urandom_range(0, 15));
  endtask

  // One bitmap: start, then bytes until the last row completes, with side traffic
  task automatic run_blit_seq();
    int guard, cut, tweak;
    int ox, w, oy, h;
    ox    = live_cfg.origin_x;
    w     = live_cfg.image_width;
    oy    = live_cfg.origin_y;
    h     = live_cfg.image_height;
    cut   = ($urandom_range(99) < 10) ? $urandom_range(1, 30) : -1;
    tweak = ($urandom_range(99) < 6) ? $urandom_range(1, 20) : -1;
    send_cmd(mk_cmd(CMD_START_BLIT, 7'($urandom), 6'($urandom), 8'($urandom)));
    guard = 0;
    while (blit_on && guard < 700) begin
      guard++;
      if (guard == cut) begin
        // abandon the image, half the time by starting over
        if ($urandom_range(1)) begin
          send_cmd(mk_cmd(CMD_START_BLIT, 7'($urandom), 6'($urandom), 8'($urandom)));
        end else begin
          return;
        end
      end
      if (guard == tweak) begin
        drain();
        case ($urandom_range(0, 2))
          0:       cfg_write(ADDR_ORIGIN_X, 32'($urandom_range(0, 127)));
          1:       cfg_write(ADDR_THRESH, 32'($urandom_range(0, 15)));
          default: cfg_write(ADDR_WIDTH, 32'(2 * $urandom_range(1, 8)));
        endcase
      end
      if ($urandom_range(99) < 8) send_side_op();
      send_cmd(mk_cmd(CMD_BLIT_BYTE, 7'($urandom), 6'($urandom), 8'($urandom)));
    end
    // a trailing padding byte arrives after the image is complete
    if ($urandom_range(99) < 15) begin
      send_cmd(mk_cmd(CMD_BLIT_BYTE, 7'($urandom), 6'($urandom), 8'($urandom)));
    end
    if ($urandom_range(99) < 40) begin
      repeat (2) begin
        send_cmd(mk_cmd(CMD_READ_BYTE, 7'($urandom_range(ox, ox + w - 1)),
                        6'($urandom_range((oy - h + 1) >> 3, oy >> 3)), 8'($urandom)));
      end
    end
  endtask

  task automatic test_pixel_and_byte_edges();
    send_cmd(mk_cmd(CMD_SET_PIXEL, 0, 0, 8'h00));
    send_cmd(mk_cmd(CMD_SET_PIXEL, SCREEN_W - 1, SCREEN_H - 1, 8'hFF));
    send_cmd(mk_cmd(CMD_SET_PIXEL, SCREEN_W, 0, 8'h00));
    send_cmd(mk_cmd(CMD_CLR_PIXEL, 0, SCREEN_H, 8'h00));
    send_cmd(mk_cmd(CMD_CLR_PIXEL, 127, 63, 8'hFF));
    send_cmd(mk_cmd(CMD_READ_BYTE, SCREEN_W - 1, N_PAGES - 1, 8'hFF));
    send_cmd(mk_cmd(CMD_WRITE_BYTE, 127, 63, 8'h5A));
    send_cmd(mk_cmd(CMD_WRITE_BYTE, 0, N_PAGES - 1, 8'hA5));
    send_cmd(mk_cmd(CMD_READ_BYTE, 0, N_PAGES, 8'h00));
    send_cmd(mk_cmd(CMD_READ_BYTE, 0, N_PAGES - 1, 8'h00));
    send_cmd(mk_cmd(CMD_NOP6, 127, 63, 8'hFF));
    send_cmd(mk_cmd(CMD_NOP7, 0, 0, 8'h00));
    send_cmd(mk_cmd(CMD_BLIT_BYTE, 0, 0, 8'hFF));
    drain();
  endtask

  task automatic test_blit_basics();
    // reset geometry: one 2-pixel row on the bottom line
    send_cmd(mk_cmd(CMD_START_BLIT, 0, 0, 8'h00));
    send_cmd(mk_cmd(CMD_BLIT_BYTE, 0, 0, 8'h10));
    send_cmd(mk_cmd(CMD_BLIT_BYTE, 0, 0, 8'hFF));
    drain();
    // two rows against the right edge, threshold above the clamp
    load_geometry(SCREEN_W - 6, 1, 6, 2, 15);
    send_cmd(mk_cmd(CMD_START_BLIT, 0, 0, 8'h00));
    send_cmd(mk_cmd(CMD_BLIT_BYTE, 0, 0, 8'hFE));
    send_cmd(mk_cmd(CMD_BLIT_BYTE, 0, 0, 8'hEF));
    send_cmd(mk_cmd(CMD_BLIT_BYTE, 0, 0, 8'hF0));
    send_cmd(mk_cmd(CMD_BLIT_BYTE, 0, 0, 8'hFF));
    drain();
    // shift the image mid-blit so its last pair falls off the store
    cfg_write(ADDR_ORIGIN_X, 32'(SCREEN_W - 4));
    cfg_write(ADDR_THRESH, 32'd0);
    send_cmd(mk_cmd(CMD_BLIT_BYTE, 0, 0, 8'h11));
    send_cmd(mk_cmd(CMD_BLIT_BYTE, 0, 0, 8'h80));
    send_cmd(mk_cmd(CMD_BLIT_BYTE, 0, 0, 8'h08));
    send_cmd(mk_cmd(CMD_READ_BYTE, SCREEN_W - 4, 0, 8'h00));
    send_cmd(mk_cmd(CMD_READ_BYTE, SCREEN_W - 1, 0, 8'h00));
    drain();
  endtask

  task automatic test_random_traffic(int pct, int quota);
    bit bad;
    int stop_at;
    idle_pct = pct;
    stop_at  = sent_items + quota;
    while (sent_items < stop_at) begin
      drain();
      bad = ($urandom_range(99) < 20);
      if (bad) begin
        // leave a blit running so the rejection has something to cancel
        if ($urandom_range(1)) begin
          send_cmd(mk_cmd(CMD_START_BLIT, 0, 0, 8'h00));
          send_cmd(mk_cmd(CMD_BLIT_BYTE, 0, 0, 8'($urandom)));
          drain();
        end
        pick_geometry(1'b1);
        send_cmd(mk_cmd(CMD_START_BLIT, 7'($urandom), 6'($urandom), 8'($urandom)));
        send_cmd(mk_cmd(CMD_BLIT_BYTE, 7'($urandom), 6'($urandom), 8'($urandom)));
      end else begin
        pick_geometry(1'b0);
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(99) < 75) begin
            run_blit_seq();
          end else begin
            repeat ($urandom_range(3, 12)) send_noise();
          end
        end
      end
    end
    drain();
  endtask

  initial begin
    foreach (fb_mem[i]) fb_mem[i] = '0;
    blit_on   = 1'b0;
    col_pair  = '0;
    cur_page  = '0;
    cur_bit   = '0;
    rows_todo = '0;
    pad_todo  = '0;
    live_cfg  = '{origin_x: 7'd0, origin_y: 6'd47, image_width: 7'd2,
                  image_height: 6'd1, gray_threshold: 4'd0};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_pixel_and_byte_edges();
    test_blit_basics();
    test_random_traffic(0, 440);
    test_random_traffic(56, 440);
    test_random_traffic(8, 440);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
`default_nettype wire

FILE: page_framebuffer_bmp_blit.f
rtl/pfb_pkg.sv
rtl/pfb_bank.sv
rtl/pfb_regs.sv
rtl/page_framebuffer_bmp_blit.sv
bench/tb_top.sv
